// File: design/rcr_pkg.sv
// shared types and constants for the ray coordinate rotation core
// sample payload structs, fixed-point angle constants and the cordic arctangent table
package rcr_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 16;
  localparam int CORDIC_STEPS   = 16;
  localparam int ANGLE_BITS     = 16;
  localparam int CFG_IDX_BITS   = 2;
  localparam int ZW             = 36;   // q2.30 angle and cordic word, with headroom
  localparam int ANGLE_SHIFT    = 17;   // q3.13 to q2.30
  localparam int ATAN_IDX_BITS  = 5;

  localparam logic [CFG_IDX_BITS-1:0] REG_POLAR   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_AZIMUTH = 2'd1;

  localparam logic signed [ZW-1:0] Q30_PI      = 36'sd3373259426;
  localparam logic signed [ZW-1:0] Q30_HALF_PI = 36'sd1686629713;
  localparam logic signed [ZW-1:0] Q30_TWO_PI  = 36'sd6746518852;
  localparam logic signed [ZW-1:0] Q30_GAIN    = 36'sd652032874;
  localparam logic signed [ANGLE_BITS-1:0] Q13_PI = 16'sd25736;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] east_sample;
    logic signed [SAMPLE_BITS-1:0] north_sample;
    logic signed [SAMPLE_BITS-1:0] up_sample;
    logic                          trace_end;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] transverse_sample;
    logic signed [SAMPLE_BITS-1:0] radial_sample;
    logic signed [SAMPLE_BITS-1:0] longitudinal_sample;
    logic                          trace_end_out;
  } out_t;

  // atan(2^-i) in q2.30
  function automatic logic signed [ZW-1:0] atan_q30(input logic [ATAN_IDX_BITS-1:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0:  r = 36'sh03243F6A8;
      5'd1:  r = 36'sh01DAC6705;
      5'd2:  r = 36'sh00FADBAFC;
      5'd3:  r = 36'sh007F56EA6;
      5'd4:  r = 36'sh003FEAB76;
      5'd5:  r = 36'sh001FFD55B;
      5'd6:  r = 36'sh000FFFAAA;
      5'd7:  r = 36'sh0007FFF55;
      5'd8:  r = 36'sh0003FFFEA;
      5'd9:  r = 36'sh0001FFFFD;
      5'd10: r = 36'sh0000FFFFF;
      5'd11: r = 36'sh00007FFFF;
      5'd12: r = 36'sh00003FFFF;
      5'd13: r = 36'sh00001FFFF;
      5'd14: r = 36'sh00000FFFF;
      5'd15: r = 36'sh000007FFF;
      5'd16: r = 36'sh000003FFF;
      5'd17: r = 36'sh000001FFF;
      5'd18: r = 36'sh000000FFF;
      5'd19: r = 36'sh0000007FF;
      5'd20: r = 36'sh0000003FF;
      5'd21: r = 36'sh0000001FF;
      5'd22: r = 36'sh0000000FF;
      5'd23: r = 36'sh00000007F;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: design/ray_coordinate_rotation_core.sv
// ray coordinate rotation core: 3x3 matrix rotation of three-component samples
// matrix rebuilt by a shared iterative cordic on each angle register write; uses rcr_pkg
// pipeline: input, product and result registers; throughput: one item per cycle unless
// out_ready_i stalls it; an angle write rebuilds the matrix with the single cordic
// iteration unit, reducing each angle first; no item is taken meanwhile
// reset: angles zero, matrix identity, pipeline empty
module ray_coordinate_rotation_core #(
  parameter int COEF_FRAC_BITS = rcr_pkg::COEF_FRAC_BITS,
  parameter int CORDIC_STEPS   = rcr_pkg::CORDIC_STEPS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rcr_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [rcr_pkg::ANGLE_BITS-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  rcr_pkg::in_t                      in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output rcr_pkg::out_t                     out_data_o
);

  localparam int SB        = rcr_pkg::SAMPLE_BITS;
  localparam int F         = COEF_FRAC_BITS;
  localparam int CW        = F + 2;
  localparam int ZW        = rcr_pkg::ZW;
  localparam int PRW       = 2 * CW;
  localparam int PW        = CW + SB;
  localparam int SW        = PW + 2;
  localparam int RSH       = 30 - F;
  localparam int RSH_M1    = (RSH > 0) ? RSH - 1 : 0;
  localparam int STEP_BITS = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(CORDIC_STEPS - 1);
  localparam logic signed [ZW-1:0] RND    = (RSH > 0) ? (ZW'(1) << RSH_M1) : '0;
  localparam logic signed [ZW-1:0] ONE_Z  = ZW'(1) << F;
  localparam logic signed [CW-1:0] ONE_C  = {2'b01, {F{1'b0}}};
  localparam logic signed [CW-1:0] MONE_C = {2'b11, {F{1'b0}}};
  localparam logic signed [PRW-1:0] CRND  = PRW'(1) << (F - 1);
  localparam logic signed [SW-1:0]  SRND  = SW'(1) << (F - 1);
  localparam logic signed [SW-1:0]  SMAX  = (SW'(1) << (SB - 1)) - SW'(1);
  localparam logic signed [SW-1:0]  SMIN  = -(SW'(1) << (SB - 1));

  typedef enum logic [2:0] {
    ST_IDLE, ST_START, ST_REDUCE, ST_QUAD, ST_ROT, ST_FIN, ST_MUL
  } build_state_e;

  build_state_e state_q;
  logic signed [rcr_pkg::ANGLE_BITS-1:0] polar_q, azimuth_q;
  logic signed [ZW-1:0] x_q, y_q, z_q, theta_q;
  logic [STEP_BITS-1:0] step_q;
  logic                 flip_q, sel_q;
  logic [1:0]           mk_q;
  logic signed [CW-1:0] a_q, b_q, c_q, d_q;
  logic signed [CW-1:0] mat_q [9];
  logic                 busy;

  // angle folding from the raw registers
  logic signed [ZW-1:0] theta_raw, phi_raw, phi_p, theta_f, phi_f;
  logic                 fold;

  assign theta_raw = ZW'(polar_q) <<< rcr_pkg::ANGLE_SHIFT;
  assign phi_raw   = ZW'(azimuth_q) <<< rcr_pkg::ANGLE_SHIFT;
  assign fold      = (theta_raw < 0) || (theta_raw > rcr_pkg::Q30_HALF_PI);
  assign phi_p     = phi_raw + rcr_pkg::Q30_PI;

  always_comb begin
    theta_f = theta_raw;
    phi_f   = phi_raw;
    if (fold) begin
      theta_f = (theta_raw < 0) ? -theta_raw : theta_raw - rcr_pkg::Q30_HALF_PI;
      phi_f   = (phi_p > rcr_pkg::Q30_PI) ? phi_p - rcr_pkg::Q30_TWO_PI : phi_p;
    end
  end

  // one cordic rotation step
  logic signed [ZW-1:0] dx, dy, at, x_rot, y_rot, z_rot;

  assign dx = y_q >>> step_q;
  assign dy = x_q >>> step_q;
  assign at = rcr_pkg::atan_q30(rcr_pkg::ATAN_IDX_BITS'(step_q));

  always_comb begin
    if (z_q >= 0) begin
      x_rot = x_q - dx;
      y_rot = y_q + dy;
      z_rot = z_q - at;
    end else begin
      x_rot = x_q + dx;
      y_rot = y_q - dy;
      z_rot = z_q + at;
    end
  end

  // final sign fix, rounding and clamp to [-1, +1]
  logic signed [ZW-1:0] xf, yf, xr, yr;
  logic signed [CW-1:0] cos_c, sin_c;

  assign xf = flip_q ? -x_q : x_q;
  assign yf = flip_q ? -y_q : y_q;
  assign xr = (xf + RND) >>> RSH;
  assign yr = (yf + RND) >>> RSH;

  always_comb begin
    if (xr > ONE_Z)       cos_c = ONE_C;
    else if (xr < -ONE_Z) cos_c = MONE_C;
    else                  cos_c = xr[CW-1:0];
    if (yr > ONE_Z)       sin_c = ONE_C;
    else if (yr < -ONE_Z) sin_c = MONE_C;
    else                  sin_c = yr[CW-1:0];
  end

  // coefficient products, one per cycle
  logic signed [PRW-1:0] cprod, cprod_r;
  logic signed [CW-1:0]  cres;

  assign cprod   = PRW'(mk_q[0] ? b_q : a_q) * PRW'(mk_q[1] ? d_q : c_q);
  assign cprod_r = (cprod + CRND) >>> F;
  assign cres    = cprod_r[CW-1:0];

  logic cfg_hit;
  assign cfg_hit = cfg_we_i &&
                   (cfg_index_i == rcr_pkg::REG_POLAR || cfg_index_i == rcr_pkg::REG_AZIMUTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      polar_q   <= '0;
      azimuth_q <= '0;
      x_q       <= '0;
      y_q       <= '0;
      z_q       <= '0;
      theta_q   <= '0;
      step_q    <= '0;
      flip_q    <= 1'b0;
      sel_q     <= 1'b0;
      mk_q      <= '0;
      a_q       <= '0;
      b_q       <= '0;
      c_q       <= '0;
      d_q       <= '0;
      for (int i = 0; i < 9; i++) mat_q[i] <= (i == 0 || i == 4 || i == 8) ? ONE_C : '0;
    end else begin
      // any angle write restarts the rebuild from both registers
      if (cfg_hit) begin
        state_q <= ST_START;
      end else begin
        unique case (state_q)
          ST_IDLE: begin
          end
          ST_START: begin
            if (polar_q == rcr_pkg::Q13_PI) begin
              // looking straight down: identity with the vertical flipped
              for (int i = 0; i < 9; i++) begin
                mat_q[i] <= (i == 8) ? MONE_C : ((i == 0 || i == 4) ? ONE_C : '0);
              end
              state_q  <= ST_IDLE;
            end else begin
              z_q     <= phi_f;
              theta_q <= theta_f;
              sel_q   <= 1'b0;
              state_q <= ST_REDUCE;
            end
          end
          ST_REDUCE: begin
            if (z_q > rcr_pkg::Q30_PI)       z_q <= z_q - rcr_pkg::Q30_TWO_PI;
            else if (z_q < -rcr_pkg::Q30_PI) z_q <= z_q + rcr_pkg::Q30_TWO_PI;
            else                             state_q <= ST_QUAD;
          end
          ST_QUAD: begin
            flip_q <= (z_q > rcr_pkg::Q30_HALF_PI) || (z_q < -rcr_pkg::Q30_HALF_PI);
            if (z_q > rcr_pkg::Q30_HALF_PI) begin
              z_q <= z_q - rcr_pkg::Q30_PI;
            end else if (z_q < -rcr_pkg::Q30_HALF_PI) begin
              z_q <= z_q + rcr_pkg::Q30_PI;
            end
            x_q     <= rcr_pkg::Q30_GAIN;
            y_q     <= '0;
            step_q  <= '0;
            state_q <= ST_ROT;
          end
          ST_ROT: begin
            x_q    <= x_rot;
            y_q    <= y_rot;
            z_q    <= z_rot;
            step_q <= step_q + STEP_BITS'(1);
            if (step_q == STEP_LAST) state_q <= ST_FIN;
          end
          ST_FIN: begin
            if (!sel_q) begin
              a_q     <= cos_c;
              b_q     <= sin_c;
              z_q     <= theta_q;
              sel_q   <= 1'b1;
              state_q <= ST_REDUCE;
            end else begin
              c_q     <= cos_c;
              d_q     <= sin_c;
              mk_q    <= '0;
              state_q <= ST_MUL;
            end
          end
          ST_MUL: begin
            // products ac, bc, ad, bd land in entries 0, 1, 6, 7
            case (mk_q)
              2'd0: mat_q[0] <= cres;
              2'd1: mat_q[1] <= cres;
              2'd2: mat_q[6] <= cres;
              default: mat_q[7] <= cres;
            endcase
            mk_q <= mk_q + 2'd1;
            if (mk_q == 2'd3) begin
              mat_q[2] <= -d_q;
              mat_q[3] <= -b_q;
              mat_q[4] <= a_q;
              mat_q[5] <= '0;
              mat_q[8] <= c_q;
              state_q  <= ST_IDLE;
            end
          end
          default: state_q <= ST_IDLE;
        endcase
      end

      if (cfg_we_i) begin
        unique case (cfg_index_i)
          rcr_pkg::REG_POLAR:   polar_q   <= $signed(cfg_data_i);
          rcr_pkg::REG_AZIMUTH: azimuth_q <= $signed(cfg_data_i);
          default: ;
        endcase
      end
    end
  end

  assign busy = (state_q != ST_IDLE);

  // sample pipeline: input register, product register, result register
  logic          va_q, vb_q, vc_q;
  logic          en_a, en_b, en_c, accept;
  rcr_pkg::in_t  ina_q;
  logic signed [PW-1:0] prod_q [9];
  logic          teb_q;
  rcr_pkg::out_t out_q;
  logic signed [SB-1:0] smp [3];
  logic signed [SW-1:0] acc [3];
  logic signed [SW-1:0] accr [3];
  logic signed [SB-1:0] res [3];

  assign en_c       = !vc_q || out_ready_i;
  assign en_b       = !vb_q || en_c;
  assign en_a       = !va_q || en_b;
  assign in_ready_o = en_a && !busy && !cfg_we_i;
  assign accept     = in_valid_i && in_ready_o;

  assign smp[0] = ina_q.east_sample;
  assign smp[1] = ina_q.north_sample;
  assign smp[2] = ina_q.up_sample;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r]  = SW'(prod_q[3*r]) + SW'(prod_q[3*r+1]) + SW'(prod_q[3*r+2]);
      accr[r] = (acc[r] + SRND) >>> F;
      if (accr[r] > SMAX)      res[r] = SMAX[SB-1:0];
      else if (accr[r] < SMIN) res[r] = SMIN[SB-1:0];
      else                     res[r] = accr[r][SB-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (en_a) va_q <= accept;
      if (en_b) vb_q <= va_q;
      if (en_c) vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) ina_q <= in_data_i;
    if (en_b) begin
      for (int r = 0; r < 3; r++) begin
        for (int j = 0; j < 3; j++) begin
          prod_q[3*r+j] <= PW'(mat_q[3*r+j]) * PW'(smp[j]);
        end
      end
      teb_q <= ina_q.trace_end;
    end
    if (en_c) begin
      out_q.transverse_sample   <= res[0];
      out_q.radial_sample       <= res[1];
      out_q.longitudinal_sample <= res[2];
      out_q.trace_end_out       <= teb_q;
    end
  end

  assign out_valid_o = vc_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_no_take_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !in_ready_o)
    else $error("item taken while the matrix is being rebuilt");

  a_write_starts_build: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_hit |=> state_q == ST_START)
    else $error("angle write did not restart the matrix build");

  a_mul_ends_build: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL && mk_q == 2'd3) |=> (state_q == ST_IDLE || state_q == ST_START))
    else $error("matrix build did not finish after the last product");

  a_pipe_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (va_q && en_b) |=> vb_q)
    else $error("item lost between input and product stage");
`endif

endmodule

// File: dv/tb.sv
// testbench for ray_coordinate_rotation_core: a queue-fed driver and a checking monitor
// expected rotations come from a cordic and matrix predictor kept in step with angle writes
// depends on rcr_pkg and the core rtl
`timescale 1ns / 100ps

module tb;

  localparam int SW = rcr_pkg::SAMPLE_BITS;
  localparam int FRAC = 16;
  localparam int STEPS = 16;
  localparam int REBUILD_PAUSE = 64;
  localparam int DRAIN_CYCLES = 20;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SEGMENTS = 20;
  localparam int SEGMENT_ITEMS = 100;

  localparam longint PI_Q30 = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint TWO_PI_Q30 = 64'sd6746518852;
  localparam longint GAIN_Q30 = 64'sd652032874;
  localparam longint ANGLE_SCALE = 64'sd131072;
  localparam longint ONE_Q16 = 64'sd65536;
  localparam longint SAMPLE_MAX = (64'sd1 <<< (SW - 1)) - 1;
  localparam longint SAMPLE_MIN = -(64'sd1 <<< (SW - 1));

  localparam logic signed [15:0] DOWN_POLAR = 16'sd25736;
  localparam logic signed [15:0] QUARTER_PI = 16'sd6434;
  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;

  localparam logic signed [SW-1:0] S_MAX = SAMPLE_MAX[SW-1:0];
  localparam logic signed [SW-1:0] S_MIN = SAMPLE_MIN[SW-1:0];

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [rcr_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [rcr_pkg::ANGLE_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready_o;
  rcr_pkg::in_t in_data = '0;
  logic out_valid_o;
  logic out_ready = 1'b0;
  rcr_pkg::out_t out_data_o;

  rcr_pkg::in_t sample_q[$];
  rcr_pkg::out_t expected_ray_q[$];
  int mismatch_count = 0;
  int stall_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // predictor state
  logic signed [15:0] polar_reg;
  logic signed [15:0] azimuth_reg;
  longint coef[9];

  ray_coordinate_rotation_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint round_half_up(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint atan_step(int i);
    case (i)
      0:  return 64'sh3243F6A8;
      1:  return 64'sh1DAC6705;
      2:  return 64'sh0FADBAFC;
      3:  return 64'sh07F56EA6;
      4:  return 64'sh03FEAB76;
      5:  return 64'sh01FFD55B;
      6:  return 64'sh00FFFAAA;
      7:  return 64'sh007FFF55;
      8:  return 64'sh003FFFEA;
      9:  return 64'sh001FFFFD;
      10: return 64'sh000FFFFF;
      11: return 64'sh0007FFFF;
      12: return 64'sh0003FFFF;
      13: return 64'sh0001FFFF;
      14: return 64'sh0000FFFF;
      15: return 64'sh00007FFF;
      default: return 64'sd0;
    endcase
  endfunction

  // rotation-mode cordic on a q2.30 angle, results in q1.16
  function automatic void cordic_sin_cos(input longint angle, output longint sin_q,
                                         output longint cos_q);
    longint x, y, z, dx, dy;
    bit flip;
    x = GAIN_Q30;
    y = 0;
    z = angle;
    flip = 1'b0;
    while (z > PI_Q30) z -= TWO_PI_Q30;
    while (z < -PI_Q30) z += TWO_PI_Q30;
    if (z > HALF_PI_Q30) begin
      z -= PI_Q30;
      flip = 1'b1;
    end else if (z < -HALF_PI_Q30) begin
      z += PI_Q30;
      flip = 1'b1;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= atan_step(i);
      end else begin
        x += dx;
        y -= dy;
        z += atan_step(i);
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cos_q = clamp(round_half_up(x, 30 - FRAC), -ONE_Q16, ONE_Q16);
    sin_q = clamp(round_half_up(y, 30 - FRAC), -ONE_Q16, ONE_Q16);
  endfunction

  function automatic void rebuild_coefficients();
    longint theta, phi, a, b, c, d;
    theta = longint'(polar_reg) * ANGLE_SCALE;
    phi = longint'(azimuth_reg) * ANGLE_SCALE;
    foreach (coef[i]) coef[i] = 0;
    // straight down: identity with the vertical axis flipped
    if (polar_reg == DOWN_POLAR) begin
      coef[0] = ONE_Q16;
      coef[4] = ONE_Q16;
      coef[8] = -ONE_Q16;
      return;
    end
    if (theta < 0 || theta > HALF_PI_Q30) begin
      theta = theta < 0 ? -theta : theta - HALF_PI_Q30;
      phi += PI_Q30;
      if (phi > PI_Q30) phi -= TWO_PI_Q30;
    end
    cordic_sin_cos(phi, b, a);
    cordic_sin_cos(theta, d, c);
    coef[0] = round_half_up(a * c, FRAC);
    coef[1] = round_half_up(b * c, FRAC);
    coef[2] = -d;
    coef[3] = -b;
    coef[4] = a;
    coef[6] = round_half_up(a * d, FRAC);
    coef[7] = round_half_up(b * d, FRAC);
    coef[8] = c;
  endfunction

  function automatic rcr_pkg::out_t rotate_sample(rcr_pkg::in_t s);
    longint comp[3];
    longint acc;
    logic signed [SW-1:0] axis[3];
    rcr_pkg::out_t r;
    comp[0] = longint'($signed(s.east_sample));
    comp[1] = longint'($signed(s.north_sample));
    comp[2] = longint'($signed(s.up_sample));
    for (int row = 0; row < 3; row++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += coef[row * 3 + j] * comp[j];
      acc = clamp(round_half_up(acc, FRAC), SAMPLE_MIN, SAMPLE_MAX);
      axis[row] = acc[SW-1:0];
    end
    r.transverse_sample = axis[0];
    r.radial_sample = axis[1];
    r.longitudinal_sample = axis[2];
    r.trace_end_out = s.trace_end;
    return r;
  endfunction

  function automatic rcr_pkg::in_t make_item(logic signed [SW-1:0] e, logic signed [SW-1:0] n,
                                              logic signed [SW-1:0] u, logic te);
    rcr_pkg::in_t it;
    it.east_sample = e;
    it.north_sample = n;
    it.up_sample = u;
    it.trace_end = te;
    return it;
  endfunction

  function automatic logic signed [SW-1:0] random_component();
    case ($urandom_range(9))
      0: return S_MAX;
      1: return S_MIN;
      2: return SW'(int'($urandom_range(64)) - 32);
      default: return SW'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] random_angle();
    case ($urandom_range(11))
      0: return 16'sd0;
      1: return DOWN_POLAR;
      2: return -DOWN_POLAR;
      3: return 16'sd32767;
      4: return 16'sh8000;
      5: return 16'sd12867;
      6: return 16'sd12868;
      7: return -16'sd12868;
      default: return 16'($urandom);
    endcase
  endfunction

  // the core rebuilds its matrix after each angle write, so let it settle first
  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    repeat (REBUILD_PAUSE) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == rcr_pkg::REG_POLAR) begin
      polar_reg = value;
      rebuild_coefficients();
    end else if (idx == rcr_pkg::REG_AZIMUTH) begin
      azimuth_reg = value;
      rebuild_coefficients();
    end
  endtask

  // checked at the falling edge so the driver's updates have settled
  task automatic wait_drained();
    while (sample_q.size() != 0 || in_valid || expected_ray_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic queue_extremes();
    sample_q.push_back(make_item(S_MAX, S_MAX, S_MAX, 1'b0));
    sample_q.push_back(make_item(S_MIN, S_MIN, S_MIN, 1'b1));
    sample_q.push_back(make_item(S_MAX, S_MAX, S_MIN, 1'b0));
    sample_q.push_back(make_item(S_MIN, S_MIN, S_MAX, 1'b1));
    sample_q.push_back(make_item('0, '0, '0, 1'b0));
    sample_q.push_back(make_item('1, '1, '1, 1'b1));
  endtask

  task automatic report_field(string field, logic signed [SW-1:0] exp_v,
                              logic signed [SW-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        expected_ray_q.push_back(rotate_sample(in_data));
      end
      if (!in_valid || in_ready_o) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= sample_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    rcr_pkg::out_t exp_ray;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (expected_ray_q.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual %h", $time, out_data_o);
          mismatch_count++;
        end else begin
          exp_ray = expected_ray_q.pop_front();
          report_field("transverse", exp_ray.transverse_sample,
                       out_data_o.transverse_sample);
          report_field("radial", exp_ray.radial_sample, out_data_o.radial_sample);
          report_field("longitudinal", exp_ray.longitudinal_sample,
                       out_data_o.longitudinal_sample);
          report_field("trace_end", SW'(exp_ray.trace_end_out),
                       SW'(out_data_o.trace_end_out));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles with no handshake and no register write
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we || (in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [1:0] pick;
    polar_reg = '0;
    azimuth_reg = '0;
    foreach (coef[i]) coef[i] = 0;
    coef[0] = ONE_Q16;
    coef[4] = ONE_Q16;
    coef[8] = ONE_Q16;
    send_idle_pct = 7;
    recv_stall_pct = 77;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: identity after reset, saturating quarter-pi, straight down, minus pi
    queue_extremes();
    wait_drained();
    write_reg(REG_SPARE_A, 16'hA5A5);
    write_reg(REG_SPARE_B, 16'h5A5A);
    write_reg(rcr_pkg::REG_POLAR, QUARTER_PI);
    write_reg(rcr_pkg::REG_AZIMUTH, QUARTER_PI);
    queue_extremes();
    wait_drained();
    write_reg(rcr_pkg::REG_POLAR, DOWN_POLAR);
    queue_extremes();
    wait_drained();
    write_reg(rcr_pkg::REG_POLAR, -DOWN_POLAR);
    write_reg(rcr_pkg::REG_AZIMUTH, 16'sd32767);
    queue_extremes();
    wait_drained();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < SEGMENTS / 3) begin
        send_idle_pct = 7;
        recv_stall_pct = 77;
      end else if (seg < 2 * SEGMENTS / 3) begin
        send_idle_pct = 77;
        recv_stall_pct = 7;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      pick = 2'($urandom_range(3));
      if (pick != 2'd1) write_reg(rcr_pkg::REG_POLAR, random_angle());
      if (pick != 2'd0) write_reg(rcr_pkg::REG_AZIMUTH, random_angle());
      if ($urandom_range(3) == 0) begin
        write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom));
      end
      for (int k = 0; k < SEGMENT_ITEMS; k++) begin
        sample_q.push_back(make_item(random_component(), random_component(),
                                     random_component(), $urandom_range(7) == 0));
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_ray_q.size() != 0) begin
      $display("%0t: %0d items never arrived", $time, expected_ray_q.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
